### rtl/core/stxetx_pkg.sv
// Types and codes shared by the STX/ETX frame parser core and its checker.
`default_nettype none

package stxetx_pkg;

    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_ENQ = 8'h05;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;

    localparam logic [1:0] FT_ENQ = 2'd0;
    localparam logic [1:0] FT_ACK = 2'd1;
    localparam logic [1:0] FT_NAK = 2'd2;

    localparam logic RK_PAYLOAD = 1'b0;
    localparam logic RK_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SUM   = 3'd1,
        ST_BAD_END   = 3'd2,
        ST_NO_FRAME  = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_TYPE = 4'd1,
        PH_CMD  = 4'd2,
        PH_LENH = 4'd3,
        PH_LENL = 4'd4,
        PH_DATA = 4'd5,
        PH_SUM  = 4'd6,
        PH_END  = 4'd7,
        PH_DONE = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [1:0]  frame_type;
        logic [7:0]  command_code;
        t_status     status;
        logic        last;
    } t_out_word;

endpackage

`default_nettype wire

### rtl/core/stx_etx_frame_parser_xor_checksum_core.sv
// STX/ETX frame parser with XOR checksum: top level.
`default_nettype none

// Takes one receive byte per cycle and hunts for STX followed by ENQ, ACK or
// NAK, then reads command, 16-bit big-endian length, payload, XOR checksum
// and ETX. Each payload byte comes out as a payload word; the ETX position
// gives one status word (bad end marker wins over bad checksum). One frame
// is tried per buffer; end_of_buffer rearms the parser and reports no frame
// or truncated when no status was given. The frame state and the result are
// computed between the parser registers and the output register, and a new
// byte is taken each cycle the output register is empty or being drained.
module stx_etx_frame_parser_xor_checksum_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  stxetx_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output stxetx_pkg::t_out_word o_out_word
);

    stxetx_pkg::t_phase    r_phase, n_phase;
    logic [1:0]            r_kind, n_kind;
    logic [7:0]            r_cmd, n_cmd;
    logic [15:0]           r_left, n_left;
    logic [15:0]           r_pos, n_pos;
    logic [7:0]            r_xor, n_xor;
    logic                  r_match, n_match;
    logic                  r_out_valid;
    stxetx_pkg::t_out_word r_out_word, n_out_word;
    logic                  n_emit;
    logic                  status_done;
    logic                  accept;
    logic [7:0]            b;

    assign b           = i_in_word.in_byte;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_cmd       = r_cmd;
        n_left      = r_left;
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_match     = r_match;
        n_emit      = 1'b0;
        status_done = 1'b0;
        n_out_word  = '0;

        case (r_phase)
            stxetx_pkg::PH_HUNT: begin
                if (b == stxetx_pkg::BYTE_STX) begin
                    n_phase = stxetx_pkg::PH_TYPE;
                end
            end
            stxetx_pkg::PH_TYPE: begin
                if (b == stxetx_pkg::BYTE_ENQ || b == stxetx_pkg::BYTE_ACK ||
                    b == stxetx_pkg::BYTE_NAK) begin
                    n_kind  = (b == stxetx_pkg::BYTE_ENQ) ? stxetx_pkg::FT_ENQ :
                              (b == stxetx_pkg::BYTE_ACK) ? stxetx_pkg::FT_ACK :
                                                            stxetx_pkg::FT_NAK;
                    n_xor   = b;
                    n_phase = stxetx_pkg::PH_CMD;
                end else if (b != stxetx_pkg::BYTE_STX) begin
                    n_phase = stxetx_pkg::PH_HUNT;
                end
            end
            stxetx_pkg::PH_CMD: begin
                n_cmd   = b;
                n_xor   = r_xor ^ b;
                n_phase = stxetx_pkg::PH_LENH;
            end
            stxetx_pkg::PH_LENH: begin
                n_left  = {b, 8'h00};
                n_xor   = r_xor ^ b;
                n_phase = stxetx_pkg::PH_LENL;
            end
            stxetx_pkg::PH_LENL: begin
                n_left  = {r_left[15:8], b};
                n_xor   = r_xor ^ b;
                n_pos   = '0;
                n_phase = (n_left != 16'd0) ? stxetx_pkg::PH_DATA : stxetx_pkg::PH_SUM;
            end
            stxetx_pkg::PH_DATA: begin
                n_xor                    = r_xor ^ b;
                n_emit                   = 1'b1;
                n_out_word.result_kind   = stxetx_pkg::RK_PAYLOAD;
                n_out_word.payload_byte  = b;
                n_out_word.payload_index = r_pos;
                n_out_word.status        = stxetx_pkg::ST_OK;
                n_pos                    = r_pos + 16'd1;
                n_left                   = r_left - 16'd1;
                if (n_left == 16'd0) begin
                    n_phase = stxetx_pkg::PH_SUM;
                end
            end
            stxetx_pkg::PH_SUM: begin
                n_match = (b == r_xor);
                n_phase = stxetx_pkg::PH_END;
            end
            stxetx_pkg::PH_END: begin
                n_emit                 = 1'b1;
                status_done            = 1'b1;
                n_out_word.result_kind = stxetx_pkg::RK_STATUS;
                n_out_word.last        = 1'b1;
                n_out_word.status      = (b != stxetx_pkg::BYTE_ETX) ? stxetx_pkg::ST_BAD_END :
                                         r_match ? stxetx_pkg::ST_OK : stxetx_pkg::ST_BAD_SUM;
                n_phase                = stxetx_pkg::PH_DONE;
            end
            default: begin
            end
        endcase

        if (i_in_word.end_of_buffer) begin
            if (!status_done) begin
                if (n_phase inside {stxetx_pkg::PH_HUNT, stxetx_pkg::PH_TYPE}) begin
                    n_emit                   = 1'b1;
                    n_out_word.result_kind   = stxetx_pkg::RK_STATUS;
                    n_out_word.payload_byte  = '0;
                    n_out_word.payload_index = '0;
                    n_out_word.status        = stxetx_pkg::ST_NO_FRAME;
                    n_out_word.last          = 1'b1;
                end else if (n_phase inside {[stxetx_pkg::PH_CMD:stxetx_pkg::PH_END]}) begin
                    n_emit                   = 1'b1;
                    n_out_word.result_kind   = stxetx_pkg::RK_STATUS;
                    n_out_word.payload_byte  = '0;
                    n_out_word.payload_index = '0;
                    n_out_word.status        = stxetx_pkg::ST_TRUNCATED;
                    n_out_word.last          = 1'b1;
                end
            end
        end

        n_out_word.frame_type   = n_kind;
        n_out_word.command_code = n_cmd;

        if (i_in_word.end_of_buffer) begin
            n_phase = stxetx_pkg::PH_HUNT;
            n_kind  = '0;
            n_cmd   = '0;
            n_left  = '0;
            n_pos   = '0;
            n_xor   = '0;
            n_match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= stxetx_pkg::PH_HUNT;
            r_kind      <= '0;
            r_cmd       <= '0;
            r_left      <= '0;
            r_pos       <= '0;
            r_xor       <= '0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_cmd       <= n_cmd;
                r_left      <= n_left;
                r_pos       <= n_pos;
                r_xor       <= n_xor;
                r_match     <= n_match;
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stxetx_checker.sv
// Port-level assertions for the STX/ETX frame parser core, with its bind.
`default_nettype none

module stxetx_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_in_ready,
    input wire                   o_out_valid,
    input wire                   i_out_ready,
    input stxetx_pkg::t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_kind == stxetx_pkg::RK_STATUS |->
        o_out_word.last && o_out_word.payload_byte == 8'd0 &&
        o_out_word.payload_index == 16'd0)
        else $error("status word with payload fields set");

    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_kind == stxetx_pkg::RK_PAYLOAD |->
        !o_out_word.last && o_out_word.status == stxetx_pkg::ST_OK)
        else $error("payload word with status fields set");

    a_no_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == stxetx_pkg::ST_NO_FRAME |->
        o_out_word.command_code == 8'd0 && o_out_word.frame_type == stxetx_pkg::FT_ENQ)
        else $error("no-frame report carries frame fields");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind stx_etx_frame_parser_xor_checksum_core stxetx_checker u_stxetx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
